// ----- sv/gda_pkg.sv -----
`timescale 1ns / 1ps

package gda_pkg;

	localparam int YEAR_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 20;
	localparam int CFG_BITS       = 16;
	localparam int CMD_BITS       = 2;
	localparam int DAY_BITS       = 5;
	localparam int MONTH_BITS     = 4;

	localparam int MIN_YEAR_RST = 1583;
	localparam int RESET_YEAR   = 2000;

	// 400-year Gregorian cycle
	localparam int DAYS_PER_CYCLE  = 146097;
	localparam int YEARS_PER_CYCLE = 400;
	localparam int MONTHS_PER_YEAR = 12;

	// signed day remainder of one 400-year cycle
	localparam int REM_BITS    = 19;
	localparam int MOD400_BITS = 9;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SET        = 2'd0,
		CMD_ADD_DAYS   = 2'd1,
		CMD_ADD_MONTHS = 2'd2,
		CMD_ADD_YEARS  = 2'd3
	} cmd_t;

	localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_BITS-1:0] MONTH_LEN [16] = '{
		5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
	};

	// leap year from the year taken mod 400
	function automatic logic leap_of(input logic [MOD400_BITS-1:0] r);
		return (r[1:0] == 2'b00) && (r != MOD400_BITS'(100)) &&
			(r != MOD400_BITS'(200)) && (r != MOD400_BITS'(300));
	endfunction

	// 0 for a month code outside 1..12
	function automatic logic [DAY_BITS-1:0] days_in_month(input logic [MONTH_BITS-1:0] m,
			input logic leap);
		logic [DAY_BITS-1:0] len;
		len = MONTH_LEN[m];
		if (m == MONTH_FEB && leap) begin
			len = len + DAY_BITS'(1);
		end
		return len;
	endfunction

endpackage

// ----- sv/gda_ifs.sv -----
`timescale 1ns / 1ps

interface gda_req_if import gda_pkg::*; #(
	parameter int YEAR_BITS  = YEAR_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic [CMD_BITS-1:0]          command;
	logic signed [COUNT_BITS-1:0] count;
	logic [DAY_BITS-1:0]          new_day;
	logic [MONTH_BITS-1:0]        new_month;
	logic [YEAR_BITS-1:0]         new_year;

	modport source (output valid, command, count, new_day, new_month, new_year, input ready);
	modport sink (input valid, command, count, new_day, new_month, new_year, output ready);
endinterface

interface gda_rsp_if import gda_pkg::*; #(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [DAY_BITS-1:0]   day_out;
	logic [MONTH_BITS-1:0] month_out;
	logic [YEAR_BITS-1:0]  year_out;
	logic                  ok;

	modport source (output valid, day_out, month_out, year_out, ok, input ready);
	modport sink (input valid, day_out, month_out, year_out, ok, output ready);
endinterface

interface gda_cfg_if import gda_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/gregorian_date_arithmetic_core.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                                     Handshake
// req      in   command, count, new_day, new_month, new_year valid/ready
// rsp      out  day_out, month_out, year_out, ok             valid/ready
// cfg      in   data (min_year)                              valid/ready, always ready
//
// One item at a time; req.ready is high only while idle. One shared multiplier does
// every constant division by reciprocal multiplication: quotient, then remainder.
//   set date, add years:  year mod 400, then the result register
//   add months:           floor divide by 12, then year mod 400
//   add days:             divide by the 400-year day count, walk whole months, and step
//                         within the last if needed (up to about 4800 months for a 399-year remainder)
// Reset: date 1 Jan 2000, min_year 1583; no clearing pass.
// A finished result waits in the finish state while the rsp register is still full.

module gregorian_date_arithmetic_core import gda_pkg::*; #(
	parameter int YEAR_BITS  = YEAR_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gda_req_if.sink   req,
	gda_rsp_if.source rsp,
	gda_cfg_if.sink   cfg
);

	localparam int MAXW = (YEAR_BITS > COUNT_BITS) ? YEAR_BITS : COUNT_BITS;
	localparam int DW   = MAXW + 1;       // divider dividend / quotient width
	localparam int YW   = MAXW + 3;       // working signed year, room for overshoot
	localparam int MINW = (YEAR_BITS < CFG_BITS) ? YEAR_BITS : CFG_BITS;
	localparam int RW   = REM_BITS;
	localparam int MW   = (DW + 1 > RW) ? DW + 1 : RW;   // constant operand of the multiplier
	localparam int PW   = DW + MW;

	// floor(x / d) = (x * ceil(2^SH / d)) >> SH for any DW-bit x when SH = DW + clog2(d)
	localparam int SH_YEAR = DW + $clog2(YEARS_PER_CYCLE);
	localparam int SH_MON  = DW + $clog2(MONTHS_PER_YEAR);
	localparam int SH_DAY  = DW + $clog2(DAYS_PER_CYCLE);
	localparam longint RCP_YEAR = ((longint'(1) << SH_YEAR) + longint'(YEARS_PER_CYCLE - 1)) /
		longint'(YEARS_PER_CYCLE);
	localparam longint RCP_MON  = ((longint'(1) << SH_MON) + longint'(MONTHS_PER_YEAR - 1)) /
		longint'(MONTHS_PER_YEAR);
	localparam longint RCP_DAY  = ((longint'(1) << SH_DAY) + longint'(DAYS_PER_CYCLE - 1)) /
		longint'(DAYS_PER_CYCLE);

	localparam logic signed [YW-1:0] YEAR_MAX = {{(YW-YEAR_BITS){1'b0}}, {YEAR_BITS{1'b1}}};

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV    = 5'b00010,
		ST_APPLY  = 5'b00100,
		ST_WALK   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// divisor in use
	typedef enum logic [1:0] {
		DIV_YEAR  = 2'd0,
		DIV_MONTH = 2'd1,
		DIV_DAY   = 2'd2
	} div_sel_t;

	state_t state_q, state_d;
	cmd_t   cmd_q, cmd_d;
	logic   neg_q, neg_d;

	// working date
	logic [DAY_BITS-1:0]    d_q, d_d;
	logic [MONTH_BITS-1:0]  m_q, m_d;
	logic signed [YW-1:0]   y_q, y_d;
	logic [MOD400_BITS-1:0] r400_q, r400_d;
	logic signed [RW-1:0]   n_q, n_d;

	// shared constant divider
	logic [DW-1:0] div_num_q, div_num_d;
	logic [RW-1:0] div_rem_q, div_rem_d;
	logic [DW-1:0] div_acc_q, div_acc_d;   // quotient
	div_sel_t      div_sel_q, div_sel_d;
	logic          div_ph_q, div_ph_d;     // 0 quotient step, 1 remainder step

	// committed date
	logic [DAY_BITS-1:0]    cur_day_q;
	logic [MONTH_BITS-1:0]  cur_month_q;
	logic [YEAR_BITS-1:0]   cur_year_q;
	logic [MOD400_BITS-1:0] cur_r400_q;
	logic [MINW-1:0]        min_year_q;

	logic                  rsp_valid_q;
	logic [DAY_BITS-1:0]   rsp_day_q;
	logic [MONTH_BITS-1:0] rsp_month_q;
	logic [YEAR_BITS-1:0]  rsp_year_q;
	logic                  rsp_ok_q;

	logic load_rsp;

	// combinational helpers
	logic                   req_take;
	cmd_t                   req_cmd;
	logic signed [DW-1:0]   cnt_w;
	logic signed [YW-1:0]   cnt_y;
	logic signed [DW-1:0]   mon_t;
	logic signed [YW-1:0]   cur_y;
	logic signed [YW-1:0]   year_sum;
	logic [DW-1:0]          mul_a;
	logic [MW-1:0]          mul_b;
	logic [MW-1:0]          mul_rcp;
	logic [MW-1:0]          mul_den;
	logic [PW-1:0]          prod;
	logic [DW-1:0]          quo_w;
	logic [DW-1:0]          rem_w;
	logic signed [YW-1:0]   acc_y;
	logic signed [YW-1:0]   acc_yrs;
	logic signed [YW-1:0]   y_mon;
	logic [MONTH_BITS-1:0]  m_mon;
	logic                   rem_nz;
	logic [DAY_BITS-1:0]    md;
	logic [MONTH_BITS-1:0]  m_dec;
	logic [MOD400_BITS-1:0] r400_dec;
	logic [MOD400_BITS-1:0] r400_inc;
	logic [DAY_BITS-1:0]    md_dec;
	logic signed [RW-1:0]   gap_s;
	logic signed [RW-1:0]   d_s;
	logic signed [RW-1:0]   back_sum;
	logic signed [YW-1:0]   min_eff;
	logic                   range_ok;
	logic                   set_ok;
	logic                   fin_ok;
	logic [DAY_BITS-1:0]    fin_day;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_take  = req.valid && (state_q == ST_IDLE);
	assign req_cmd   = cmd_t'(req.command);

	assign cnt_w    = {{(DW-COUNT_BITS){req.count[COUNT_BITS-1]}}, req.count};
	assign cnt_y    = {{(YW-COUNT_BITS){req.count[COUNT_BITS-1]}}, req.count};
	assign cur_y    = $signed({{(YW-YEAR_BITS){1'b0}}, cur_year_q});
	assign year_sum = cur_y + cnt_y;
	// zero-based month plus count, floor-divided by 12 later
	assign mon_t    = $signed({{(DW-MONTH_BITS){1'b0}}, cur_month_q - MONTH_JAN}) + cnt_w;

	// divisor constants
	always_comb begin
		case (div_sel_q)
			DIV_MONTH: begin
				mul_rcp = MW'(RCP_MON);
				mul_den = MW'(MONTHS_PER_YEAR);
			end
			DIV_DAY: begin
				mul_rcp = MW'(RCP_DAY);
				mul_den = MW'(DAYS_PER_CYCLE);
			end
			default: begin
				mul_rcp = MW'(RCP_YEAR);
				mul_den = MW'(YEARS_PER_CYCLE);
			end
		endcase
	end

	// step 0: dividend times reciprocal; step 1: quotient times divisor
	assign mul_a = div_ph_q ? div_acc_q : div_num_q;
	assign mul_b = div_ph_q ? mul_den : mul_rcp;
	assign prod  = PW'(mul_a) * PW'(mul_b);
	assign rem_w = div_num_q - prod[DW-1:0];

	always_comb begin
		case (div_sel_q)
			DIV_MONTH: quo_w = DW'(prod >> SH_MON);
			DIV_DAY:   quo_w = DW'(prod >> SH_DAY);
			default:   quo_w = DW'(prod >> SH_YEAR);
		endcase
	end

	assign acc_y   = $signed({{(YW-DW){1'b0}}, div_acc_q});
	assign acc_yrs = acc_y * $signed(YW'(YEARS_PER_CYCLE));
	assign rem_nz  = (div_rem_q != RW'(0));

	// floor division of a negative month offset: round the quotient down
	always_comb begin
		if (!neg_q) begin
			y_mon = y_q + acc_y;
			m_mon = div_rem_q[MONTH_BITS-1:0] + MONTH_JAN;
		end else if (rem_nz) begin
			y_mon = y_q - acc_y - YW'(1);
			m_mon = MONTH_BITS'(MONTHS_PER_YEAR + 1) - div_rem_q[MONTH_BITS-1:0];
		end else begin
			y_mon = y_q - acc_y;
			m_mon = MONTH_JAN;
		end
	end

	assign md       = days_in_month(m_q, leap_of(r400_q));
	assign r400_inc = (r400_q == MOD400_BITS'(YEARS_PER_CYCLE - 1)) ? MOD400_BITS'(0) :
		r400_q + MOD400_BITS'(1);
	assign r400_dec = (r400_q == MOD400_BITS'(0)) ? MOD400_BITS'(YEARS_PER_CYCLE - 1) :
		r400_q - MOD400_BITS'(1);
	assign m_dec    = (m_q == MONTH_JAN) ? MONTH_DEC : m_q - MONTH_BITS'(1);
	assign md_dec   = days_in_month(m_dec, leap_of((m_q == MONTH_JAN) ? r400_dec : r400_q));

	assign gap_s    = $signed({{(RW-DAY_BITS){1'b0}}, md - d_q});
	assign d_s      = $signed({{(RW-DAY_BITS){1'b0}}, d_q});
	assign back_sum = n_q + d_s;

	assign min_eff  = $signed({{(YW-MINW){1'b0}}, min_year_q});
	assign range_ok = (y_q >= min_eff) && (y_q <= YEAR_MAX);
	// md is zero for a bad month, so this also rejects months outside 1..12
	assign set_ok   = (d_q != DAY_BITS'(0)) && (d_q <= md);
	assign fin_ok   = range_ok && ((cmd_q != CMD_SET) || set_ok);
	// month and year adds clamp to the end of the target month
	assign fin_day  = (d_q > md) ? md : d_q;

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		neg_d     = neg_q;
		d_d       = d_q;
		m_d       = m_q;
		y_d       = y_q;
		r400_d    = r400_q;
		n_d       = n_q;
		div_num_d = div_num_q;
		div_rem_d = div_rem_q;
		div_acc_d = div_acc_q;
		div_sel_d = div_sel_q;
		div_ph_d  = div_ph_q;
		load_rsp  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					cmd_d     = req_cmd;
					d_d       = cur_day_q;
					m_d       = cur_month_q;
					y_d       = cur_y;
					r400_d    = cur_r400_q;
					neg_d     = 1'b0;
					div_rem_d = RW'(0);
					div_acc_d = DW'(0);
					div_sel_d = DIV_YEAR;
					div_ph_d  = 1'b0;
					div_num_d = DW'(0);
					state_d   = ST_DIV;
					case (req_cmd)
						CMD_SET: begin
							d_d       = req.new_day;
							m_d       = req.new_month;
							y_d       = $signed({{(YW-YEAR_BITS){1'b0}}, req.new_year});
							div_num_d = {{(DW-YEAR_BITS){1'b0}}, req.new_year};
						end
						CMD_ADD_DAYS: begin
							neg_d     = cnt_w[DW-1];
							div_num_d = cnt_w[DW-1] ? DW'(-cnt_w) : DW'(cnt_w);
							div_sel_d = DIV_DAY;
						end
						CMD_ADD_MONTHS: begin
							neg_d     = mon_t[DW-1];
							div_num_d = mon_t[DW-1] ? DW'(-mon_t) : DW'(mon_t);
							div_sel_d = DIV_MONTH;
						end
						CMD_ADD_YEARS: begin
							// an out-of-range sum divides garbage and is rejected at finish
							y_d       = year_sum;
							div_num_d = year_sum[DW-1:0];
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			ST_DIV: begin
				if (!div_ph_q) begin
					div_acc_d = quo_w;
					div_ph_d  = 1'b1;
				end else begin
					div_rem_d = RW'(rem_w);
					if (div_sel_q == DIV_YEAR) begin
						r400_d  = MOD400_BITS'(rem_w);
						state_d = ST_FINISH;
					end else begin
						state_d = ST_APPLY;
					end
				end
			end

			ST_APPLY: begin
				if (cmd_q == CMD_ADD_DAYS) begin
					// whole 400-year cycles first, truncated toward zero
					y_d     = neg_q ? (y_q - acc_yrs) : (y_q + acc_yrs);
					n_d     = neg_q ? -$signed(div_rem_q) : $signed(div_rem_q);
					state_d = ST_WALK;
				end else begin
					y_d       = y_mon;
					m_d       = m_mon;
					div_num_d = y_mon[DW-1:0];
					div_rem_d = RW'(0);
					div_acc_d = DW'(0);
					div_sel_d = DIV_YEAR;
					div_ph_d  = 1'b0;
					state_d   = ST_DIV;
				end
			end

			ST_WALK: begin
				if (n_q == RW'(0)) begin
					state_d = ST_FINISH;
				end else if (!n_q[RW-1]) begin
					if (n_q > gap_s) begin
						// step to the first of next month
						n_d = n_q - gap_s - RW'(1);
						d_d = DAY_BITS'(1);
						if (m_q == MONTH_DEC) begin
							m_d    = MONTH_JAN;
							y_d    = y_q + YW'(1);
							r400_d = r400_inc;
						end else begin
							m_d = m_q + MONTH_BITS'(1);
						end
					end else begin
						d_d = d_q + n_q[DAY_BITS-1:0];
						n_d = RW'(0);
					end
				end else begin
					if (back_sum[RW-1] || (back_sum == RW'(0))) begin
						// step to the last day of the previous month
						n_d = back_sum;
						m_d = m_dec;
						d_d = md_dec;
						if (m_q == MONTH_JAN) begin
							y_d    = y_q - YW'(1);
							r400_d = r400_dec;
						end
					end else begin
						d_d = d_q + n_q[DAY_BITS-1:0];
						n_d = RW'(0);
					end
				end
			end

			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_day_q   <= DAY_BITS'(1);
			cur_month_q <= MONTH_JAN;
			cur_year_q  <= YEAR_BITS'(RESET_YEAR);
			cur_r400_q  <= MOD400_BITS'(RESET_YEAR % YEARS_PER_CYCLE);
			min_year_q  <= MINW'(MIN_YEAR_RST);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				min_year_q <= cfg.data[MINW-1:0];
			end
			if (load_rsp && fin_ok) begin
				cur_day_q   <= fin_day;
				cur_month_q <= m_q;
				cur_year_q  <= y_q[YEAR_BITS-1:0];
				cur_r400_q  <= r400_q;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		neg_q     <= neg_d;
		d_q       <= d_d;
		m_q       <= m_d;
		y_q       <= y_d;
		r400_q    <= r400_d;
		n_q       <= n_d;
		div_num_q <= div_num_d;
		div_rem_q <= div_rem_d;
		div_acc_q <= div_acc_d;
		div_sel_q <= div_sel_d;
		div_ph_q  <= div_ph_d;
		if (load_rsp) begin
			rsp_ok_q    <= fin_ok;
			rsp_day_q   <= fin_ok ? fin_day : cur_day_q;
			rsp_month_q <= fin_ok ? m_q : cur_month_q;
			rsp_year_q  <= fin_ok ? y_q[YEAR_BITS-1:0] : cur_year_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.day_out   = rsp_day_q;
	assign rsp.month_out = rsp_month_q;
	assign rsp.year_out  = rsp_year_q;
	assign rsp.ok        = rsp_ok_q;

endmodule
